FILE: rtl/bad_pkg.sv
// ----------------------------------------------------------------------------
// bad_pkg
// Shared types and constants of the banked address decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bad_pkg;

  typedef enum logic [3:0] {
    RG_BOOT     = 4'd0,
    RG_ROM      = 4'd1,
    RG_VRAM     = 4'd2,
    RG_EXTRAM   = 4'd3,
    RG_WRAM     = 4'd4,
    RG_OAM      = 4'd5,
    RG_JOYPAD   = 4'd6,
    RG_TIMER    = 4'd7,
    RG_SOUND    = 4'd8,
    RG_VIDEO    = 4'd9,
    RG_HRAM     = 4'd10,
    RG_LOCAL    = 4'd11,
    RG_UNMAPPED = 4'd12,
    RG_CONTROL  = 4'd13
  } bad_region_e;

  localparam int unsigned AddrW   = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned PhysW   = 21;
  localparam int unsigned DmaSrcW = 13;
  localparam int unsigned RomBankW = 7;
  localparam int unsigned RamBankW = 2;

  localparam logic [7:0]  FillByte    = 8'h2D;
  localparam logic [15:0] AddrBootReg = 16'hFF50;
  localparam logic [15:0] AddrDmaReg  = 16'hFF46;
  localparam logic [15:0] AddrIeReg   = 16'hFFFF;
  localparam logic [15:0] AddrIfReg   = 16'hFF0F;
  localparam logic [15:0] AddrJoypad  = 16'hFF00;
  localparam logic [7:0]  DmaPageLo   = 8'h80;
  localparam logic [7:0]  DmaPageHi   = 8'hDF;

  // controller window select, address bits 14:13
  localparam logic [1:0] CtlRamEn   = 2'd0;
  localparam logic [1:0] CtlRomLo   = 2'd1;
  localparam logic [1:0] CtlRomHi   = 2'd2;
  localparam logic [1:0] CtlMode    = 2'd3;

  typedef struct packed {
    logic                boot_active;
    logic [RomBankW-1:0] rom_bank;
    logic [RamBankW-1:0] ram_bank;
    logic                bank_mode;
    logic [ByteW-1:0]    int_enable;
    logic [ByteW-1:0]    int_flags;
  } bad_state_t;

  typedef struct packed {
    bad_region_e        region;
    logic [PhysW-1:0]   phys_address;
    logic [ByteW-1:0]   read_data;
    logic               dma_start;
    logic [DmaSrcW-1:0] dma_source;
  } bad_result_t;

  localparam bad_state_t StateReset = '{
    boot_active: 1'b1,
    rom_bank:    7'd1,
    ram_bank:    2'd0,
    bank_mode:   1'b0,
    int_enable:  8'd0,
    int_flags:   8'd0
  };

endpackage

`default_nettype wire

FILE: rtl/bad_decode.sv
// ----------------------------------------------------------------------------
// bad_decode
// Address decode, bank mapping and next-state logic for one bus access.
// ----------------------------------------------------------------------------
`default_nettype none

module bad_decode (
  input  logic                            is_write_i,
  input  logic [bad_pkg::AddrW-1:0]       address_i,
  input  logic [bad_pkg::ByteW-1:0]       write_data_i,
  input  logic [bad_pkg::ByteW-1:0]       cart_type_i,
  input  bad_pkg::bad_state_t             state_i,
  output bad_pkg::bad_result_t            result_o,
  output bad_pkg::bad_state_t             state_d_o
);

  logic       banking_on;
  logic       mode_on;
  logic [7:0] lo;
  logic [4:0] rom_lo;

  assign banking_on = cart_type_i inside {[8'd1:8'd3]};
  assign mode_on    = cart_type_i inside {8'd2, 8'd3};
  assign lo         = address_i[7:0];
  assign rom_lo     = (write_data_i[4:0] == 5'd0) ? 5'd1 : write_data_i[4:0];

  always_comb begin
    result_o.region       = bad_pkg::RG_UNMAPPED;
    result_o.phys_address = '0;
    result_o.read_data    = '0;
    result_o.dma_start    = 1'b0;
    result_o.dma_source   = '0;
    state_d_o             = state_i;

    if (address_i[15] == 1'b0) begin
      if (is_write_i) begin
        result_o.region = bad_pkg::RG_CONTROL;
        case (address_i[14:13])
          bad_pkg::CtlRamEn: begin
          end
          bad_pkg::CtlRomLo: begin
            if (banking_on) state_d_o.rom_bank = {state_i.rom_bank[6:5], rom_lo};
          end
          bad_pkg::CtlRomHi: begin
            if (banking_on) begin
              if (state_i.bank_mode) begin
                state_d_o.ram_bank = write_data_i[1:0];
              end else begin
                state_d_o.rom_bank = {write_data_i[1:0], state_i.rom_bank[4:0]};
              end
            end
          end
          bad_pkg::CtlMode: begin
            if (mode_on) state_d_o.bank_mode = write_data_i[0];
          end
          default: begin
          end
        endcase
      end else if (address_i[15:8] == 8'h00 && state_i.boot_active) begin
        result_o.region       = bad_pkg::RG_BOOT;
        result_o.phys_address = {5'd0, address_i};
      end else if (address_i[14] == 1'b0) begin
        result_o.region       = bad_pkg::RG_ROM;
        result_o.phys_address = {5'd0, address_i};
      end else begin
        result_o.region       = bad_pkg::RG_ROM;
        result_o.phys_address = {state_i.rom_bank, address_i[13:0]};
      end
    end else if (address_i[15:13] == 3'b100) begin
      result_o.region       = bad_pkg::RG_VRAM;
      result_o.phys_address = {8'd0, address_i[12:0]};
    end else if (address_i[15:13] == 3'b101) begin
      result_o.region       = bad_pkg::RG_EXTRAM;
      result_o.phys_address = {6'd0, state_i.ram_bank, address_i[12:0]};
    end else if (address_i < 16'hFE00) begin
      result_o.region       = bad_pkg::RG_WRAM;
      result_o.phys_address = {8'd0, address_i[12:0]};
    end else if (address_i[15:8] == 8'hFE) begin
      result_o.phys_address = {13'd0, lo};
      if (lo < 8'hA0) begin
        result_o.region = bad_pkg::RG_OAM;
      end else begin
        result_o.region = bad_pkg::RG_UNMAPPED;
        if (!is_write_i) result_o.read_data = bad_pkg::FillByte;
      end
    end else if (address_i == bad_pkg::AddrBootReg) begin
      result_o.region       = bad_pkg::RG_LOCAL;
      result_o.phys_address = {13'd0, lo};
      if (is_write_i) begin
        state_d_o.boot_active = (write_data_i == 8'd0);
      end else begin
        result_o.read_data = {7'd0, ~state_i.boot_active};
      end
    end else if (address_i == bad_pkg::AddrIeReg) begin
      result_o.region       = bad_pkg::RG_LOCAL;
      result_o.phys_address = {13'd0, lo};
      if (is_write_i) begin
        state_d_o.int_enable = write_data_i;
      end else begin
        result_o.read_data = state_i.int_enable;
      end
    end else if (address_i == bad_pkg::AddrDmaReg && is_write_i) begin
      result_o.region       = bad_pkg::RG_LOCAL;
      result_o.phys_address = {13'd0, lo};
      if (write_data_i >= bad_pkg::DmaPageLo && write_data_i <= bad_pkg::DmaPageHi) begin
        result_o.dma_start  = 1'b1;
        result_o.dma_source = {write_data_i[4:0], 8'd0};
      end
    end else if (lo[7]) begin
      result_o.region       = bad_pkg::RG_HRAM;
      result_o.phys_address = {14'd0, address_i[6:0]};
    end else begin
      result_o.phys_address = {13'd0, lo};
      if (lo < 8'h10) begin
        if (address_i == bad_pkg::AddrJoypad) begin
          result_o.region = bad_pkg::RG_JOYPAD;
        end else if (lo inside {[8'h03:8'h07]}) begin
          result_o.region = bad_pkg::RG_TIMER;
        end else if (address_i == bad_pkg::AddrIfReg) begin
          result_o.region = bad_pkg::RG_LOCAL;
          if (is_write_i) begin
            state_d_o.int_flags = write_data_i;
          end else begin
            result_o.read_data = state_i.int_flags;
          end
        end else begin
          result_o.region = bad_pkg::RG_UNMAPPED;
          if (!is_write_i) result_o.read_data = bad_pkg::FillByte;
        end
      end else if (lo < 8'h40) begin
        result_o.region = bad_pkg::RG_SOUND;
      end else begin
        result_o.region = bad_pkg::RG_VIDEO;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bad_regs.sv
// ----------------------------------------------------------------------------
// bad_regs
// Cartridge type register, bank controller and local registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bad_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [bad_pkg::ByteW-1:0] cfg_data_i,
  input  logic                      update_i,
  input  bad_pkg::bad_state_t       state_d_i,
  output bad_pkg::bad_state_t       state_o,
  output logic [bad_pkg::ByteW-1:0] cart_type_o
);

  bad_pkg::bad_state_t       state_q;
  logic [bad_pkg::ByteW-1:0] cart_type_q;

  assign cfg_ready_o = 1'b1;
  assign state_o     = state_q;
  assign cart_type_o = cart_type_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cart_type_q <= '0;
    end else if (cfg_valid_i) begin
      cart_type_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bad_pkg::StateReset;
    end else if (update_i) begin
      state_q <= state_d_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/banked_address_decoder.sv
// ----------------------------------------------------------------------------
// banked_address_decoder
// Bus address decoder with cartridge bank controller and local registers.
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one cpu bus access per item: tuser is the write flag,
//   tdata holds the address and the write byte. m_axis returns one
//   decoded item per access: tuser is the target region, tdata holds
//   the physical offset, read byte, dma start flag and dma source.
//   cfg carries the cartridge type byte; write it only while idle.
//   each access is latched in an input register, decoded combinationally
//   and stored in a result register, from which m_axis presents it;
//   one access per cycle is sustained while m_axis does not stall.
//   bank, boot and interrupt registers update as an access moves into
//   the result register, so the next access already sees the change.
//   reset maps the boot rom, selects rom bank 1, ram bank 0, mode 0,
//   clears interrupt registers and the cartridge type, and empties
//   both registers. when m_axis stalls, the result register holds and
//   s_axis keeps accepting until the input register is also full.
// ----------------------------------------------------------------------------
`default_nettype none

module banked_address_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] address, [23:16] write_data
  input  logic [23:0] s_axis_tdata,
  // [0] is_write
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [20:0] phys_address, [28:21] read_data, [29] dma_start,
  // [42:30] dma_source, [47:43] zero
  output logic [47:0] m_axis_tdata,
  // [3:0] region
  output logic [3:0]  m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  logic                      in_valid_q;
  logic                      in_write_q;
  logic [bad_pkg::AddrW-1:0] in_addr_q;
  logic [bad_pkg::ByteW-1:0] in_data_q;
  logic                      out_valid_q;
  bad_pkg::bad_result_t      out_q;
  bad_pkg::bad_result_t      result_d;
  bad_pkg::bad_state_t       state;
  bad_pkg::bad_state_t       state_d;
  logic [bad_pkg::ByteW-1:0] cart_type;
  logic                      advance;
  logic                      move;

  assign advance       = !out_valid_q || m_axis_tready;
  assign move          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_write_q <= s_axis_tuser[0];
      in_addr_q  <= s_axis_tdata[15:0];
      in_data_q  <= s_axis_tdata[23:16];
    end
  end

  bad_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .update_i    (move),
    .state_d_i   (state_d),
    .state_o     (state),
    .cart_type_o (cart_type)
  );

  bad_decode u_decode (
    .is_write_i   (in_write_q),
    .address_i    (in_addr_q),
    .write_data_i (in_data_q),
    .cart_type_i  (cart_type),
    .state_i      (state),
    .result_o     (result_d),
    .state_d_o    (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.region;
  assign m_axis_tdata  = {5'd0, out_q.dma_source, out_q.dma_start,
                          out_q.read_data, out_q.phys_address};

  // dma requests only come from the local dma register
  a_dma_local : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.dma_start) |-> (out_q.region == bad_pkg::RG_LOCAL))
    else $error("dma start outside local region");

  // low rom bank bits never select bank zero
  a_rom_bank_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state.rom_bank[4:0] != 5'd0)
    else $error("rom bank low bits zero");

  // input side only stalls when both registers are full and output is held
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without cause");

  // bank state is untouched while no item moves into the result register
  a_state_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !move |=> $stable(state))
    else $error("state changed without an item");

endmodule

`default_nettype wire
